### rtl/vhbc_pkg.sv
// Shared types, constants and helpers for the voxel hidden-block cull.
// Depends on nothing; vhbc_seq and the top level import it.
package vhbc_pkg;

    localparam int DEF_CHUNK_WIDTH = 16;
    localparam int DEF_WORLD_TOP   = 256;
    localparam int SLAB_LEVELS     = 18;

    localparam logic [4:0] CULL_LO = 5'd1;
    localparam logic [4:0] CULL_HI = 5'd16;

    localparam logic [7:0] AIR     = 8'd0;
    localparam logic [7:0] STONE   = 8'd1;
    localparam logic [7:0] DIRT    = 8'd3;
    localparam logic [7:0] BEDROCK = 8'd7;
    localparam logic [7:0] SKIP    = 8'd255;

    // Item actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_Y   = 2'd0;
    localparam logic [1:0] CFG_OPAQUE_A = 2'd1;
    localparam logic [1:0] CFG_OPAQUE_B = 2'd2;
    localparam logic [1:0] CFG_OPAQUE_C = 2'd3;

    typedef struct packed {
        logic [7:0] base_y;
        logic [7:0] opaque_id_a;
        logic [7:0] opaque_id_b;
        logic [7:0] opaque_id_c;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] pos_x;
        logic [3:0] pos_z;
        logic [4:0] level;
        logic [7:0] block_id;
    } in_item_t;

    typedef struct packed {
        logic [7:0] culled_id;
        logic       hidden;
        logic       slab_nonempty;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESULT
    } seq_state_t;

    function automatic logic is_opaque(input logic [7:0] id, input cfg_t cfg);
        return (id == cfg.opaque_id_a) || (id == cfg.opaque_id_b) ||
               (id == cfg.opaque_id_c) || (id == SKIP);
    endfunction

endpackage

### rtl/vhbc_store.sv
// Single-port block-id store with a registered read.
// Depends on nothing but its parameters.
module vhbc_store #(
    parameter int DEPTH = 4608,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/vhbc_seq.sv
// Item sequencer: takes write, clear and query beats, drives the store port
// and gathers the six neighbour reads of a query. Depends on vhbc_pkg.
module vhbc_seq #(
    parameter int CHUNK_WIDTH = vhbc_pkg::DEF_CHUNK_WIDTH,
    parameter int WORLD_TOP   = vhbc_pkg::DEF_WORLD_TOP,
    parameter int AW          = $clog2(CHUNK_WIDTH * CHUNK_WIDTH * vhbc_pkg::SLAB_LEVELS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vhbc_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_stall,
    input  vhbc_pkg::in_item_t  item,
    output logic                res_valid,
    input  logic                res_ready,
    output vhbc_pkg::out_item_t res,
    output logic                mem_we,
    output logic                mem_re,
    output logic [AW-1:0]       mem_addr,
    output logic [7:0]          mem_wdata,
    input  logic [7:0]          mem_rd_data
);
    import vhbc_pkg::*;

    localparam logic [AW-1:0] OFF_X = AW'(1);
    localparam logic [AW-1:0] OFF_Z = AW'(CHUNK_WIDTH);
    localparam logic [AW-1:0] OFF_Y = AW'(CHUNK_WIDTH * CHUNK_WIDTH);

    seq_state_t    state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    logic          nonempty_reg, nonempty_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          can_hide_reg, can_hide_next;
    logic          skip_below_reg, skip_below_next;
    logic [7:0]    center_id_reg, center_id_next;
    logic          ok_reg, ok_next;

    logic          accept;
    logic          pos_ok;
    logic [AW-1:0] addr_in;
    logic [8:0]    world_y;
    logic          in_cull;
    logic          interior;
    logic [AW-1:0] nb_addr;

    assign accept = item_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        pos_ok   = (32'(item.pos_x) < CHUNK_WIDTH) && (32'(item.pos_z) < CHUNK_WIDTH) &&
                   (32'(item.level) < SLAB_LEVELS);
        addr_in  = AW'((32'(item.level) * CHUNK_WIDTH + 32'(item.pos_z)) * CHUNK_WIDTH
                   + 32'(item.pos_x));
        world_y  = {1'b0, cfg.base_y} + 9'(item.level) - 9'd1;
        in_cull  = (item.level >= CULL_LO) && (item.level <= CULL_HI);
        interior = (item.pos_x != 4'd0) && (32'(item.pos_x) != CHUNK_WIDTH - 1) &&
                   (item.pos_z != 4'd0) && (32'(item.pos_z) != CHUNK_WIDTH - 1);
    end

    // Neighbour order: x-1, x+1, z-1, z+1, below, above
    always_comb
    begin
        case (step_reg)
            3'd1:    nb_addr = addr_reg - OFF_X;
            3'd2:    nb_addr = addr_reg + OFF_X;
            3'd3:    nb_addr = addr_reg - OFF_Z;
            3'd4:    nb_addr = addr_reg + OFF_Z;
            3'd5:    nb_addr = addr_reg - OFF_Y;
            default: nb_addr = addr_reg + OFF_Y;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        nonempty_next   = nonempty_reg;
        addr_next       = addr_reg;
        can_hide_next   = can_hide_reg;
        skip_below_next = skip_below_reg;
        center_id_next  = center_id_reg;
        ok_next         = ok_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = addr_in;
        mem_wdata       = item.block_id;
        res_valid       = 1'b0;
        res.culled_id   = mem_rd_data;
        res.hidden      = 1'b0;
        res.slab_nonempty = nonempty_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_WRITE:
                        begin
                            mem_we = pos_ok;
                            if (pos_ok && in_cull && (item.block_id != AIR))
                            begin
                                nonempty_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            nonempty_next = 1'b0;
                        end
                        ACT_QUERY:
                        begin
                            if (pos_ok)
                            begin
                                // Read the centre now; neighbours follow if it can hide
                                mem_re          = 1'b1;
                                addr_next       = addr_in;
                                can_hide_next   = in_cull && interior &&
                                                  (32'(world_y) < WORLD_TOP - 1);
                                skip_below_next = (world_y == 9'd0);
                                step_next       = 3'd1;
                                state_next      = can_hide_next ? ST_READ : ST_RESULT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                mem_re   = 1'b1;
                mem_addr = nb_addr;
                if (step_reg == 3'd1)
                begin
                    center_id_next = mem_rd_data;
                    ok_next        = is_opaque(mem_rd_data, cfg);
                end
                else
                begin
                    // Data of read step-1; the below read lands at step six
                    ok_next = ok_reg && (is_opaque(mem_rd_data, cfg) ||
                              ((step_reg == 3'd6) && skip_below_reg));
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Last read data holds here: the above neighbour, or the centre
                res_valid = 1'b1;
                if (can_hide_reg)
                begin
                    res.hidden    = ok_reg && is_opaque(mem_rd_data, cfg);
                    res.culled_id = res.hidden ? SKIP : center_id_reg;
                end
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= 3'd0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        can_hide_reg   <= can_hide_next;
        skip_below_reg <= skip_below_next;
        center_id_reg  <= center_id_next;
        ok_reg         <= ok_next;
    end

    assign item_stall = (state_reg != ST_IDLE);

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in the same cycle");

    a_result_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) |-> (!mem_re && !mem_we))
        else $error("store accessed while a result is offered");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg >= 3'd1 && step_reg <= 3'd6))
        else $error("neighbour step out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result dropped or changed before it was taken");

endmodule

### rtl/voxel_hidden_block_cull.sv
// Top level of the voxel hidden-block cull: configuration registers, the
// sequencer, the block-id store and the result register. Depends on vhbc_pkg.
//
// Usage
//   item channel (item_valid / item_stall / item): one beat per action. A write
//   stores block_id at (pos_x, pos_z, level); a clear drops the nonempty flag;
//   a query reads the addressed id and, for an interior culled block below the
//   world's top layer, its six neighbours, then returns one result beat. Writes,
//   clears, unused actions and out-of-range positions give no result.
//   result channel (result_valid / result_stall / result): culled_id, hidden
//   and the current slab_nonempty flag.
//   cfg_we / cfg_index / cfg_data: write base_y and the three opaque ids; write
//   only while the block is idle.
// Timing
//   Write and clear beats never raise item_stall. An interior query makes seven
//   reads through the single store port, the centre and then its neighbours,
//   one per cycle, then offers its result. A query that can never hide reads
//   the centre only. item_stall is high while a query is in flight.
// Reset and stalls
//   Reset clears the flag and the sequencer and returns the configuration to
//   its defaults; store contents are undefined until written. A stalled result
//   beat waits in the output register, and the block holds the next query's
//   result until it drains.
module voxel_hidden_block_cull #(
    parameter int CHUNK_WIDTH = vhbc_pkg::DEF_CHUNK_WIDTH,
    parameter int WORLD_TOP   = vhbc_pkg::DEF_WORLD_TOP
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  vhbc_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output vhbc_pkg::out_item_t result
);
    import vhbc_pkg::*;

    localparam int DEPTH = CHUNK_WIDTH * CHUNK_WIDTH * SLAB_LEVELS;
    localparam int AW    = $clog2(DEPTH);

    cfg_t      cfg_reg, cfg_next;
    logic      result_valid_reg, result_valid_next;
    out_item_t result_reg, result_next;

    logic          res_valid;
    logic          res_ready;
    out_item_t     res;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rd_data;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_Y:   cfg_next.base_y      = cfg_data;
                CFG_OPAQUE_A: cfg_next.opaque_id_a = cfg_data;
                CFG_OPAQUE_B: cfg_next.opaque_id_b = cfg_data;
                CFG_OPAQUE_C: cfg_next.opaque_id_c = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_y      <= 8'd0;
            cfg_reg.opaque_id_a <= STONE;
            cfg_reg.opaque_id_b <= DIRT;
            cfg_reg.opaque_id_c <= BEDROCK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vhbc_seq #(
        .CHUNK_WIDTH (CHUNK_WIDTH),
        .WORLD_TOP   (WORLD_TOP),
        .AW          (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rd_data (mem_rd_data)
    );

    vhbc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .re      (mem_re),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (mem_rd_data)
    );

    // Output register: load when empty or draining, hold while stalled
    assign res_ready = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (res_ready)
        begin
            result_valid_next = res_valid;
            if (res_valid)
            begin
                result_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
